/* src/i2cs_pkg.sv */
package i2cs_pkg;

   // Transmit buffer geometry
   localparam int MAX_LEN  = 64;
   localparam int TX_AW    = $clog2(MAX_LEN);
   localparam int RX_SLOTS = (MAX_LEN < 64) ? MAX_LEN : 64;
   localparam int BC_W     = 7;

   // Controller control-register mask bits
   localparam logic [7:0] M_AA  = 8'h01;
   localparam logic [7:0] M_SI  = 8'h02;
   localparam logic [7:0] M_STO = 8'h04;
   localparam logic [7:0] M_STA = 8'h08;
   localparam logic [7:0] M_EN  = 8'h10;

   // Master status codes
   localparam logic [7:0] ST_BUS_ERR      = 8'h00;
   localparam logic [7:0] ST_START        = 8'h08;
   localparam logic [7:0] ST_RSTART       = 8'h10;
   localparam logic [7:0] ST_SLA_W_ACK    = 8'h18;
   localparam logic [7:0] ST_SLA_W_NACK   = 8'h20;
   localparam logic [7:0] ST_DATA_TX_ACK  = 8'h28;
   localparam logic [7:0] ST_DATA_TX_NACK = 8'h30;
   localparam logic [7:0] ST_ARB_LOST     = 8'h38;
   localparam logic [7:0] ST_SLA_R_ACK    = 8'h40;
   localparam logic [7:0] ST_SLA_R_NACK   = 8'h48;
   localparam logic [7:0] ST_DATA_RX_ACK  = 8'h50;
   localparam logic [7:0] ST_DATA_RX_NACK = 8'h58;

   typedef enum logic [1:0] {
      PH_IDLE, PH_WAIT_STOP, PH_WAIT_START, PH_RUN
   } phase_type;

   typedef enum logic [1:0] {
      OP_LOAD, OP_START, OP_STATUS, OP_TIMEOUT
   } opcode_type;

   typedef enum logic [2:0] {
      WK_DATA, WK_SET, WK_CLR, WK_RX, WK_STATUS
   } wr_kind_type;

   typedef enum logic [2:0] {
      ERR_OK, ERR_BUS, ERR_NACK, ERR_ARB, ERR_BAD_STATUS,
      ERR_START_TO, ERR_RUN_TO, ERR_STOP_TO
   } err_type;

   typedef enum logic [2:0] {
      CSR_DEV_ADDR, CSR_READ_MODE, CSR_LENGTH, CSR_STOP_AT_END,
      CSR_NEED_ACK, CSR_RUN_LIMIT, CSR_START_LIMIT
   } csr_idx_type;

   typedef struct packed {
      logic [6:0]      dev_addr;
      logic            read_mode;
      logic [BC_W-1:0] length;
      logic            stop_at_end;
      logic            need_ack;
      logic [3:0]      run_limit;
      logic [3:0]      start_limit;
   } cfg_type;

   typedef struct packed {
      phase_type       phase;
      logic [BC_W-1:0] bc;
      logic [3:0]      start_left;
      logic [3:0]      run_left;
      logic            irq;
   } seq_state_type;

   typedef struct packed {
      wr_kind_type kind;
      logic [7:0]  value;
      logic [5:0]  index;
   } wr_beat_type;

   // All result beats of one item plus the per-item status
   typedef struct packed {
      wr_beat_type [3:0] beats;
      logic [1:0]        last_idx;
      logic              irq;
      logic              done;
      err_type           err;
      phase_type         phase;
   } burst_type;

endpackage

/* src/i2cs_if.sv */
// Request channel
interface i2cs_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] status_code;
   logic [7:0] data_byte;
   logic [5:0] load_index;
   logic       stop_pending;

   modport source (output valid, opcode, status_code, data_byte, load_index, stop_pending,
                   input ready);
   modport sink   (input valid, opcode, status_code, data_byte, load_index, stop_pending,
                   output ready);
endinterface

// Response channel
interface i2cs_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] write_kind;
   logic [7:0] write_value;
   logic [5:0] byte_index;
   logic       irq_enable;
   logic       done_res;
   logic [2:0] error_code;
   logic [1:0] phase;
   logic       last;

   modport source (output valid, write_kind, write_value, byte_index, irq_enable, done_res,
                   error_code, phase, last, input ready);
   modport sink   (input valid, write_kind, write_value, byte_index, irq_enable, done_res,
                   error_code, phase, last, output ready);
endinterface

/* src/i2cs_step.sv */
module i2cs_step
   import i2cs_pkg::*;
(
   input  logic [1:0]    opcode,
   input  logic [7:0]    status_code,
   input  logic [7:0]    rx_byte,
   input  logic          stop_pending,
   input  logic [7:0]    tx_byte,
   input  cfg_type       cfg,
   input  seq_state_type cur,
   output seq_state_type nxt,
   output burst_type     burst
);

   logic [2:0] n;
   logic       do_take, do_rx_clr, do_send, do_addr_rx;
   logic       do_restart, do_begin, do_finish;
   err_type    bus_err, fin_err;

   // One transfer step: decide the actions, then emit beats in order
   always_comb begin
      nxt        = cur;
      burst      = '0;
      n          = '0;
      do_take    = 1'b0;
      do_rx_clr  = 1'b0;
      do_send    = 1'b0;
      do_addr_rx = 1'b0;
      do_restart = 1'b0;
      do_begin   = 1'b0;
      do_finish  = 1'b0;
      bus_err    = ERR_OK;
      fin_err    = ERR_OK;

      unique case (opcode_type'(opcode))
         OP_LOAD: begin
         end
         OP_START: begin
            nxt.start_left = cfg.start_limit;
            nxt.run_left   = cfg.run_limit;
            if (stop_pending) nxt.phase = PH_WAIT_STOP;
            else do_begin = 1'b1;
         end
         OP_STATUS: begin
            if (cur.irq) begin
               unique case (status_code) inside
                  ST_BUS_ERR: bus_err = ERR_BUS;
                  ST_START, ST_RSTART: begin
                     nxt.phase = PH_RUN;
                     burst.beats[n[1:0]] = '{kind: WK_DATA, value: {cfg.dev_addr, cfg.read_mode},
                                             index: '0};
                     n = n + 3'd1;
                     burst.beats[n[1:0]] = '{kind: WK_CLR, value: M_STA | M_SI, index: '0};
                     n = n + 3'd1;
                  end
                  ST_SLA_W_NACK, ST_DATA_TX_NACK: begin
                     if (cfg.need_ack) bus_err = ERR_NACK;
                     else do_send = 1'b1;
                  end
                  ST_SLA_W_ACK, ST_DATA_TX_ACK: do_send = 1'b1;
                  ST_ARB_LOST: bus_err = ERR_ARB;
                  ST_SLA_R_NACK: begin
                     if (cfg.need_ack) bus_err = ERR_NACK;
                     else do_addr_rx = 1'b1;
                  end
                  ST_SLA_R_ACK: do_addr_rx = 1'b1;
                  ST_DATA_RX_ACK: begin
                     do_take   = 1'b1;
                     do_rx_clr = 1'b1;
                  end
                  ST_DATA_RX_NACK: begin
                     do_take   = 1'b1;
                     do_finish = 1'b1;
                  end
                  default: bus_err = ERR_BAD_STATUS;
               endcase
            end
         end
         OP_TIMEOUT: begin
            unique case (cur.phase)
               PH_WAIT_STOP: begin
                  if (stop_pending) begin
                     do_finish = 1'b1;
                     fin_err   = ERR_STOP_TO;
                  end else begin
                     do_begin = 1'b1;
                  end
               end
               PH_WAIT_START, PH_RUN: begin
                  if (cur.start_left != 4'd0) begin
                     nxt.start_left = cur.start_left - 4'd1;
                     do_restart     = 1'b1;
                  end else begin
                     do_finish = 1'b1;
                     fin_err   = (cur.phase == PH_RUN) ? ERR_RUN_TO : ERR_START_TO;
                  end
               end
               default: begin
               end
            endcase
         end
         default: begin
         end
      endcase

      // Received byte: emit while it fits, count with saturation
      if (do_take) begin
         if (32'(cur.bc) < RX_SLOTS) begin
            burst.beats[n[1:0]] = '{kind: WK_RX, value: rx_byte, index: 6'(cur.bc)};
            n = n + 3'd1;
         end
         if (cur.bc != {BC_W{1'b1}}) nxt.bc = cur.bc + BC_W'(1);
      end

      // Drop ack ahead of the final byte
      if (do_rx_clr) begin
         burst.beats[n[1:0]] = '{kind: WK_CLR, index: '0,
                                 value: (({1'b0, nxt.bc} + 8'd1) == {1'b0, cfg.length}) ?
                                        (M_STA | M_SI | M_AA) : (M_STA | M_SI)};
         n = n + 3'd1;
      end

      // Next transmit byte or end of a write
      if (do_send) begin
         if (cur.bc < cfg.length) begin
            burst.beats[n[1:0]] = '{kind: WK_DATA, value: tx_byte, index: '0};
            n = n + 3'd1;
            burst.beats[n[1:0]] = '{kind: WK_CLR, value: M_STA | M_SI, index: '0};
            n = n + 3'd1;
            nxt.bc = cur.bc + BC_W'(1);
         end else begin
            do_finish = 1'b1;
         end
      end

      // Address acked for a read
      if (do_addr_rx) begin
         if (cfg.length > 7'd1) begin
            burst.beats[n[1:0]] = '{kind: WK_SET, value: M_AA, index: '0};
            n = n + 3'd1;
         end
         burst.beats[n[1:0]] = '{kind: WK_CLR, value: M_STA | M_SI, index: '0};
         n = n + 3'd1;
      end

      // Bus error: retry while the run budget lasts
      if (bus_err != ERR_OK) begin
         if (cur.run_left != 4'd0) begin
            nxt.run_left   = cur.run_left - 4'd1;
            nxt.start_left = cfg.start_limit;
            do_restart     = 1'b1;
         end else begin
            do_finish = 1'b1;
            fin_err   = bus_err;
         end
      end

      if (do_restart) begin
         burst.beats[n[1:0]] = '{kind: WK_CLR, value: M_STA | M_SI, index: '0};
         n = n + 3'd1;
         burst.beats[n[1:0]] = '{kind: WK_SET, value: M_STO, index: '0};
         n = n + 3'd1;
         if (stop_pending) begin
            nxt.irq   = 1'b0;
            nxt.phase = PH_WAIT_STOP;
         end else begin
            do_begin = 1'b1;
         end
      end

      if (do_begin) begin
         nxt.bc    = '0;
         nxt.phase = PH_WAIT_START;
         nxt.irq   = 1'b1;
         burst.beats[n[1:0]] = '{kind: WK_CLR, value: M_EN | M_STA | M_SI | M_AA, index: '0};
         n = n + 3'd1;
         burst.beats[n[1:0]] = '{kind: WK_SET, value: M_EN | M_STA, index: '0};
         n = n + 3'd1;
      end

      if (do_finish) begin
         nxt.phase  = PH_IDLE;
         nxt.irq    = 1'b0;
         burst.done = 1'b1;
         burst.err  = fin_err;
         if (fin_err != ERR_OK || cfg.stop_at_end) begin
            burst.beats[n[1:0]] = '{kind: WK_CLR, value: M_STA | M_SI | M_AA, index: '0};
            n = n + 3'd1;
            burst.beats[n[1:0]] = '{kind: WK_SET, value: M_STO, index: '0};
            n = n + 3'd1;
         end
      end

      // Nothing written: one status-only beat
      if (n == 3'd0) begin
         burst.beats[0] = '{kind: WK_STATUS, value: '0, index: '0};
         n = 3'd1;
      end

      burst.last_idx = 2'(n - 3'd1);
      burst.irq      = nxt.irq;
      burst.phase    = nxt.phase;
   end

endmodule

/* src/i2c_master_transfer_sequencer.sv */
// Channel    Direction  Handshake          Payload
// req_bus    in         valid/ready        opcode, status_code, data_byte, load_index,
//                                          stop_pending
// rsp_bus    out        valid/ready        write_kind, write_value, byte_index, irq_enable,
//                                          done_res, error_code, phase, last
// APB        in         psel/penable       paddr[4:2] selects the register, pready tied high
//
// An item enters the step register at the edge that accepts it, with its transmit byte
// read from the buffer RAM at that edge; the step retires into the beat register once it
// is empty or drains its last beat, making its first beat valid. An item holds the beat
// register for 1 to 4 beats, one per rsp_bus transfer, so each item's beat count sets the
// sustained rate. Load items write the RAM at accept and produce no beat. Reset is
// synchronous and clears control state; the buffer RAM is not cleared. A stalled rsp_bus
// holds the beat register and, once the step register is full, holds req_bus ready low.
module i2c_master_transfer_sequencer
   import i2cs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   i2cs_req_if.sink    req_bus,
   i2cs_rsp_if.source  rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   cfg_type       cfg_ff, cfg_in;
   seq_state_type state_ff, state_in, step_nxt;
   burst_type     step_burst, burst_ff;

   logic          e_valid_ff, e_valid_in;
   logic [1:0]    e_op_ff;
   logic [7:0]    e_st_ff, e_dat_ff;
   logic          e_sp_ff;

   logic [7:0]    tx_mem [MAX_LEN];
   logic [7:0]    rd_data_ff;
   logic          rd_oob_ff;
   logic [BC_W-1:0]  rd_bc;
   logic [TX_AW-1:0] rd_addr;

   logic          b_valid_ff, b_valid_in;
   logic [1:0]    b_ptr_ff, b_ptr_in;

   logic          req_acc, is_load, csr_wr, e_fire, b_last, b_drain;
   csr_idx_type   csr_idx;
   wr_beat_type   beat;

   // Configuration port
   assign pready  = 1'b1;
   assign csr_wr  = psel && penable && pwrite && pready;
   assign csr_idx = csr_idx_type'(paddr[4:2]);

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr) begin
         unique case (csr_idx)
            CSR_DEV_ADDR:    cfg_in.dev_addr    = pwdata[6:0];
            CSR_READ_MODE:   cfg_in.read_mode   = pwdata[0];
            CSR_LENGTH:      cfg_in.length      = pwdata[BC_W-1:0];
            CSR_STOP_AT_END: cfg_in.stop_at_end = pwdata[0];
            CSR_NEED_ACK:    cfg_in.need_ack    = pwdata[0];
            CSR_RUN_LIMIT:   cfg_in.run_limit   = pwdata[3:0];
            CSR_START_LIMIT: cfg_in.start_limit = pwdata[3:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         CSR_DEV_ADDR:    prdata = {25'd0, cfg_ff.dev_addr};
         CSR_READ_MODE:   prdata = {31'd0, cfg_ff.read_mode};
         CSR_LENGTH:      prdata = {{(32-BC_W){1'b0}}, cfg_ff.length};
         CSR_STOP_AT_END: prdata = {31'd0, cfg_ff.stop_at_end};
         CSR_NEED_ACK:    prdata = {31'd0, cfg_ff.need_ack};
         CSR_RUN_LIMIT:   prdata = {28'd0, cfg_ff.run_limit};
         CSR_START_LIMIT: prdata = {28'd0, cfg_ff.start_limit};
         default:         prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{dev_addr: '0, read_mode: 1'b0, length: '0, stop_at_end: 1'b1,
                     need_ack: 1'b1, run_limit: 4'd2, start_limit: 4'd10};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Handshake and step-register control
   assign b_last  = (b_ptr_ff == burst_ff.last_idx);
   assign b_drain = b_valid_ff && rsp_bus.ready && b_last;
   assign e_fire  = e_valid_ff && (!b_valid_ff || b_drain);

   assign req_bus.ready = !e_valid_ff || e_fire;
   assign req_acc       = req_bus.valid && req_bus.ready;
   assign is_load       = (opcode_type'(req_bus.opcode) == OP_LOAD);

   always_comb begin
      e_valid_in = e_valid_ff;
      if (req_acc && !is_load) e_valid_in = 1'b1;
      else if (e_fire) e_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else e_valid_ff <= e_valid_in;
   end

   always_ff @(posedge clock) begin
      if (req_acc && !is_load) begin
         e_op_ff  <= req_bus.opcode;
         e_st_ff  <= req_bus.status_code;
         e_dat_ff <= req_bus.data_byte;
         e_sp_ff  <= req_bus.stop_pending;
      end
   end

   // Transmit buffer RAM; the read address forwards the byte count of a step retiring now
   assign rd_bc   = e_fire ? step_nxt.bc : state_ff.bc;
   assign rd_addr = TX_AW'(rd_bc);

   always_ff @(posedge clock) begin
      if (req_acc && is_load && (32'(req_bus.load_index) < MAX_LEN)) begin
         tx_mem[TX_AW'(req_bus.load_index)] <= req_bus.data_byte;
      end
      if (req_acc && !is_load) begin
         rd_data_ff <= tx_mem[rd_addr];
         rd_oob_ff  <= (32'(rd_bc) >= MAX_LEN);
      end
   end

   // Transfer step logic
   i2cs_step u_step (
      .opcode       (e_op_ff),
      .status_code  (e_st_ff),
      .rx_byte      (e_dat_ff),
      .stop_pending (e_sp_ff),
      .tx_byte      (rd_oob_ff ? 8'd0 : rd_data_ff),
      .cfg          (cfg_ff),
      .cur          (state_ff),
      .nxt          (step_nxt),
      .burst        (step_burst)
   );

   assign state_in = e_fire ? step_nxt : state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '{phase: PH_IDLE, bc: '0, start_left: '0, run_left: '0, irq: 1'b0};
      end else begin
         state_ff <= state_in;
      end
   end

   // Beat register: one beat per cycle from the retired step while rsp_bus is ready
   always_comb begin
      b_valid_in = b_valid_ff;
      b_ptr_in   = b_ptr_ff;
      if (e_fire) begin
         b_valid_in = 1'b1;
         b_ptr_in   = '0;
      end else if (b_drain) begin
         b_valid_in = 1'b0;
      end else if (b_valid_ff && rsp_bus.ready) begin
         b_ptr_in = b_ptr_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         b_ptr_ff   <= '0;
      end else begin
         b_valid_ff <= b_valid_in;
         b_ptr_ff   <= b_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (e_fire) burst_ff <= step_burst;
   end

   assign beat                = burst_ff.beats[b_ptr_ff];
   assign rsp_bus.valid       = b_valid_ff;
   assign rsp_bus.write_kind  = beat.kind;
   assign rsp_bus.write_value = beat.value;
   assign rsp_bus.byte_index  = beat.index;
   assign rsp_bus.irq_enable  = burst_ff.irq;
   assign rsp_bus.done_res    = burst_ff.done;
   assign rsp_bus.error_code  = burst_ff.err;
   assign rsp_bus.phase       = burst_ff.phase;
   assign rsp_bus.last        = b_last;

`ifndef NO_ASSERTIONS
   a_fire_loads_first: assert property (@(posedge clock) disable iff (reset)
      e_fire |=> b_valid_ff && (b_ptr_ff == 2'd0))
      else $error("retired step did not load the beat register at its first beat");

   a_burst_continues: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && !b_last |=> b_valid_ff)
      else $error("beat register emptied before the last beat");

   a_done_is_idle: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && burst_ff.done |-> (burst_ff.phase == PH_IDLE) && !burst_ff.irq)
      else $error("finished transfer not idle");

   a_err_needs_done: assert property (@(posedge clock) disable iff (reset)
      b_valid_ff && (burst_ff.err != ERR_OK) |-> burst_ff.done)
      else $error("error code without done");

   a_state_holds: assert property (@(posedge clock) disable iff (reset)
      !e_fire |=> $stable(state_ff))
      else $error("transfer state changed without a retiring step");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import i2cs_pkg::*;

   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 10;

   typedef struct packed {
      opcode_type op;
      logic [7:0] status;
      logic [7:0] data;
      logic [5:0] index;
      logic       stop_busy;
   } bus_item_type;

   // One controller write beat as the block should emit it
   typedef struct {
      wr_beat_type w;
      logic        irq;
      logic        done;
      err_type     err;
      phase_type   ph;
      logic        last;
   } ctrl_write_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        psel, penable, pwrite;
   logic [4:0]  paddr;
   logic [31:0] pwdata;
   logic [31:0] prdata;
   logic        pready;

   i2cs_req_if req_bus ();
   i2cs_rsp_if rsp_bus ();

   i2c_master_transfer_sequencer dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   bus_item_type   bus_items[$];
   ctrl_write_type pending_writes[$];
   bus_item_type   drive_item;
   int          queued_total;
   int          failures;
   int          quiet_cycles;
   int          cyc;
   logic        steady;

   // Transfer state mirror
   cfg_type     cfg;
   phase_type   ph;
   logic [6:0]  bcount;
   logic [3:0]  start_left;
   logic [3:0]  run_left;
   logic        irq_on;
   logic [7:0]  txbuf [MAX_LEN];

   // Writes of the step being worked out
   wr_beat_type step_writes [4];
   int          n_writes;
   logic        step_fin;
   err_type     step_err;

   // ---------------------------------------------------------------
   // Transfer sequencing mirror
   // ---------------------------------------------------------------
   function automatic void add_write(wr_kind_type kind, logic [7:0] value,
                                     logic [5:0] index);
      if (n_writes < 4) begin
         step_writes[n_writes] = '{kind: kind, value: value, index: index};
         n_writes++;
      end
   endfunction

   function automatic void begin_xfer();
      bcount = '0;
      ph = PH_WAIT_START;
      add_write(WK_CLR, M_EN | M_STA | M_SI | M_AA, '0);
      add_write(WK_SET, M_EN | M_STA, '0);
      irq_on = 1'b1;
   endfunction

   function automatic void restart_xfer(logic stop_busy);
      add_write(WK_CLR, M_STA | M_SI, '0);
      add_write(WK_SET, M_STO, '0);
      if (stop_busy) begin
         irq_on = 1'b0;
         ph = PH_WAIT_STOP;
      end else begin
         begin_xfer();
      end
   endfunction

   function automatic void finish_xfer(err_type err);
      ph = PH_IDLE;
      irq_on = 1'b0;
      step_fin = 1'b1;
      step_err = err;
      if (err != ERR_OK || cfg.stop_at_end) begin
         add_write(WK_CLR, M_STA | M_SI | M_AA, '0);
         add_write(WK_SET, M_STO, '0);
      end
   endfunction

   // received byte: emitted only while it fits, count saturates
   function automatic void take_byte(logic [7:0] b);
      if (bcount < RX_SLOTS) add_write(WK_RX, b, bcount[5:0]);
      if (bcount < 7'd127) bcount++;
   endfunction

   function automatic void send_byte();
      logic [7:0] b;
      if (bcount < cfg.length) begin
         b = (bcount < MAX_LEN) ? txbuf[bcount[5:0]] : 8'h00;
         add_write(WK_DATA, b, '0);
         add_write(WK_CLR, M_STA | M_SI, '0);
         bcount++;
      end else begin
         finish_xfer(ERR_OK);
      end
   endfunction

   function automatic void step_transfer(bus_item_type it);
      err_type err;
      ctrl_write_type e;
      n_writes = 0;
      step_fin = 1'b0;
      step_err = ERR_OK;
      err = ERR_OK;
      if (it.op == OP_LOAD) begin
         txbuf[it.index] = it.data;
         return;
      end
      case (it.op)
         OP_START: begin
            start_left = cfg.start_limit;
            run_left = cfg.run_limit;
            if (it.stop_busy) ph = PH_WAIT_STOP;
            else begin_xfer();
         end
         OP_STATUS: begin
            // status events are masked while the interrupt is off
            if (irq_on) begin
               case (it.status)
                  ST_BUS_ERR: err = ERR_BUS;
                  ST_START, ST_RSTART: begin
                     ph = PH_RUN;
                     add_write(WK_DATA, {cfg.dev_addr, cfg.read_mode}, '0);
                     add_write(WK_CLR, M_STA | M_SI, '0);
                  end
                  ST_SLA_W_NACK, ST_DATA_TX_NACK: begin
                     if (cfg.need_ack) err = ERR_NACK;
                     else send_byte();
                  end
                  ST_SLA_W_ACK, ST_DATA_TX_ACK: send_byte();
                  ST_ARB_LOST: err = ERR_ARB;
                  ST_SLA_R_ACK, ST_SLA_R_NACK: begin
                     if (it.status == ST_SLA_R_NACK && cfg.need_ack) begin
                        err = ERR_NACK;
                     end else begin
                        if (cfg.length > 7'd1) add_write(WK_SET, M_AA, '0);
                        add_write(WK_CLR, M_STA | M_SI, '0);
                     end
                  end
                  ST_DATA_RX_ACK: begin
                     take_byte(it.data);
                     if (({1'b0, bcount} + 8'd1) == {1'b0, cfg.length})
                        add_write(WK_CLR, M_STA | M_SI | M_AA, '0);
                     else
                        add_write(WK_CLR, M_STA | M_SI, '0);
                  end
                  ST_DATA_RX_NACK: begin
                     take_byte(it.data);
                     finish_xfer(ERR_OK);
                  end
                  default: err = ERR_BAD_STATUS;
               endcase
               if (err != ERR_OK) begin
                  if (run_left > 0) begin
                     run_left--;
                     start_left = cfg.start_limit;
                     restart_xfer(it.stop_busy);
                  end else begin
                     finish_xfer(err);
                  end
               end
            end
         end
         default: begin
            // retry interval expired
            case (ph)
               PH_WAIT_STOP: begin
                  if (it.stop_busy) finish_xfer(ERR_STOP_TO);
                  else begin_xfer();
               end
               PH_WAIT_START, PH_RUN: begin
                  if (start_left > 0) begin
                     start_left--;
                     restart_xfer(it.stop_busy);
                  end else begin
                     finish_xfer((ph == PH_RUN) ? ERR_RUN_TO : ERR_START_TO);
                  end
               end
               default: ;
            endcase
         end
      endcase
      if (n_writes == 0) add_write(WK_STATUS, '0, '0);
      for (int k = 0; k < n_writes; k++) begin
         e.w = step_writes[k];
         e.irq = irq_on;
         e.done = step_fin;
         e.err = step_err;
         e.ph = ph;
         e.last = (k == n_writes - 1);
         pending_writes.push_back(e);
      end
   endfunction

   // ---------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------
   task automatic queue_item(opcode_type op, logic [7:0] st, logic [7:0] dat,
                             logic [5:0] idx, logic sb);
      bus_item_type it;
      it = '{op: op, status: st, data: dat, index: idx, stop_busy: sb};
      bus_items.push_back(it);
      queued_total++;
   endtask

   // status event with occasional noise in front of it
   task automatic queue_event(logic [7:0] st);
      if ($urandom_range(99) < 8)
         queue_item(opcode_type'($urandom_range(3)), 8'($urandom_range(255)),
                    8'($urandom_range(255)), 6'($urandom_range(63)),
                    1'($urandom_range(1)));
      queue_item(OP_STATUS, st, 8'($urandom_range(255)), 6'($urandom_range(63)),
                 $urandom_range(99) < 10);
   endtask

   // one well-formed transfer for the current settings, random content
   task automatic queue_transfer();
      queue_item(OP_START, 8'($urandom_range(255)), 8'($urandom_range(255)),
                 6'($urandom_range(63)), $urandom_range(7) == 0);
      if ($urandom_range(5) == 0)
         queue_item(OP_TIMEOUT, 8'($urandom_range(255)), 8'($urandom_range(255)),
                    6'($urandom_range(63)), $urandom_range(3) == 0);
      queue_event($urandom_range(1) ? ST_START : ST_RSTART);
      if (cfg.read_mode) begin
         queue_event(($urandom_range(19) == 0) ? ST_SLA_R_NACK : ST_SLA_R_ACK);
         for (int k = 1; k < cfg.length; k++) queue_event(ST_DATA_RX_ACK);
         queue_event(ST_DATA_RX_NACK);
      end else begin
         queue_event(($urandom_range(19) == 0) ? ST_SLA_W_NACK : ST_SLA_W_ACK);
         for (int k = 0; k < cfg.length; k++)
            queue_event(($urandom_range(19) == 0) ? ST_DATA_TX_NACK : ST_DATA_TX_ACK);
      end
   endtask

   task automatic csr_write(csr_idx_type idx, logic [31:0] value);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      @(posedge clock);
      psel <= 1'b0;
      penable <= 1'b0;
      case (idx)
         CSR_DEV_ADDR:    cfg.dev_addr = value[6:0];
         CSR_READ_MODE:   cfg.read_mode = value[0];
         CSR_LENGTH:      cfg.length = value[6:0];
         CSR_STOP_AT_END: cfg.stop_at_end = value[0];
         CSR_NEED_ACK:    cfg.need_ack = value[0];
         CSR_RUN_LIMIT:   cfg.run_limit = value[3:0];
         default:         cfg.start_limit = value[3:0];
      endcase
   endtask

   task automatic set_config(int dev, int rm, int len, int stop, int ack, int runl,
                             int startl);
      csr_write(CSR_DEV_ADDR, dev);
      csr_write(CSR_READ_MODE, rm);
      csr_write(CSR_LENGTH, len);
      csr_write(CSR_STOP_AT_END, stop);
      csr_write(CSR_NEED_ACK, ack);
      csr_write(CSR_RUN_LIMIT, runl);
      csr_write(CSR_START_LIMIT, startl);
   endtask

   // drain everything in flight, then let the pipeline settle
   task automatic wait_quiet();
      while (bus_items.size() != 0 || req_bus.valid || pending_writes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic flag_failure(string what);
      failures++;
      if (failures <= 10) $display("ERROR: %s", what);
   endtask

   // ---------------------------------------------------------------
   // Request driver
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      cyc <= cyc + 1;
      steady <= (cyc >= 600 && cyc < 1100);
   end

   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (!req_bus.valid || req_bus.ready) begin
         if (bus_items.size() != 0 && (steady || $urandom_range(99) >= 22)) begin
            drive_item = bus_items.pop_front();
            req_bus.valid <= 1'b1;
            req_bus.opcode <= drive_item.op;
            req_bus.status_code <= drive_item.status;
            req_bus.data_byte <= drive_item.data;
            req_bus.load_index <= drive_item.index;
            req_bus.stop_pending <= drive_item.stop_busy;
         end else begin
            req_bus.valid <= 1'b0;
         end
      end
   end

   // Predict on every accepted request beat
   always @(posedge clock) begin
      if (!reset && req_bus.valid && req_bus.ready)
         step_transfer('{op: opcode_type'(req_bus.opcode), status: req_bus.status_code,
                         data: req_bus.data_byte, index: req_bus.load_index,
                         stop_busy: req_bus.stop_pending});
   end

   // ---------------------------------------------------------------
   // Result side: backpressure and checking
   // ---------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) rsp_bus.ready <= 1'b0;
      else rsp_bus.ready <= steady || ($urandom_range(99) >= 22);
   end

   always @(posedge clock) begin
      ctrl_write_type e;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_writes.size() == 0) begin
            flag_failure($sformatf("unexpected beat kind=%0d value=%02h",
                                   rsp_bus.write_kind, rsp_bus.write_value));
         end else begin
            e = pending_writes.pop_front();
            if (rsp_bus.write_kind !== e.w.kind || rsp_bus.write_value !== e.w.value ||
                rsp_bus.byte_index !== e.w.index || rsp_bus.irq_enable !== e.irq ||
                rsp_bus.done_res !== e.done || rsp_bus.error_code !== e.err ||
                rsp_bus.phase !== e.ph || rsp_bus.last !== e.last)
               flag_failure($sformatf({"beat mismatch exp kind=%0d val=%02h idx=%0d irq=%0b",
                  " done=%0b err=%0d ph=%0d last=%0b | got kind=%0d val=%02h idx=%0d",
                  " irq=%0b done=%0b err=%0d ph=%0d last=%0b"},
                  e.w.kind, e.w.value, e.w.index, e.irq, e.done, e.err, e.ph, e.last,
                  rsp_bus.write_kind, rsp_bus.write_value, rsp_bus.byte_index,
                  rsp_bus.irq_enable, rsp_bus.done_res, rsp_bus.error_code,
                  rsp_bus.phase, rsp_bus.last));
         end
      end
   end

   // Watchdog: stalls with no traffic on any port
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready) ||
          psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------
   initial begin
      int phase_start;
      reset = 1'b1;
      psel = 1'b0;
      penable = 1'b0;
      pwrite = 1'b0;
      paddr = '0;
      pwdata = '0;
      req_bus.valid = 1'b0;
      req_bus.opcode = '0;
      req_bus.status_code = '0;
      req_bus.data_byte = '0;
      req_bus.load_index = '0;
      req_bus.stop_pending = 1'b0;
      rsp_bus.ready = 1'b0;
      failures = 0;
      queued_total = 0;
      quiet_cycles = 0;
      cyc = 0;
      steady = 1'b0;
      cfg = '{dev_addr: 7'd0, read_mode: 1'b0, length: 7'd0, stop_at_end: 1'b1,
              need_ack: 1'b1, run_limit: 4'd2, start_limit: 4'd10};
      ph = PH_IDLE;
      bcount = '0;
      start_left = '0;
      run_left = '0;
      irq_on = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: write transfer, retries and timeouts
      set_config(127, 0, 2, 0, 1, 1, 0);
      // fill the whole transmit buffer so no unwritten entry is ever sent
      for (int i = 0; i < MAX_LEN; i++)
         queue_item(OP_LOAD, 8'h00, (i == 0) ? 8'h00 : (i == MAX_LEN - 1) ? 8'hFF
                    : 8'($urandom_range(255)), 6'(i), 1'b0);
      queue_item(OP_TIMEOUT, 8'h00, 8'h00, 6'd0, 1'b0);        // timeout while idle
      queue_item(OP_STATUS, ST_START, 8'h00, 6'd0, 1'b0);      // masked interrupt
      queue_item(OP_START, 8'h00, 8'h00, 6'd0, 1'b1);          // stop still pending
      queue_item(OP_TIMEOUT, 8'h00, 8'h00, 6'd0, 1'b1);        // stop never clears
      queue_item(OP_START, 8'h00, 8'h00, 6'd0, 1'b0);
      queue_item(OP_STATUS, ST_START, 8'h00, 6'd0, 1'b0);
      queue_item(OP_START, 8'hFF, 8'hFF, 6'd63, 1'b0);         // start while busy
      queue_item(OP_STATUS, ST_RSTART, 8'h00, 6'd0, 1'b0);
      queue_item(OP_STATUS, ST_SLA_W_ACK, 8'h00, 6'd0, 1'b0);
      queue_item(OP_STATUS, ST_DATA_TX_NACK, 8'h00, 6'd0, 1'b0); // nack, full restart
      queue_item(OP_TIMEOUT, 8'h00, 8'h00, 6'd0, 1'b0);        // start timeout
      queue_item(OP_START, 8'h00, 8'h00, 6'd0, 1'b0);
      queue_item(OP_STATUS, ST_START, 8'h00, 6'd0, 1'b0);
      queue_item(OP_TIMEOUT, 8'h00, 8'h00, 6'd0, 1'b0);        // run timeout
      queue_item(OP_START, 8'h00, 8'h00, 6'd0, 1'b0);
      queue_item(OP_STATUS, 8'h5A, 8'h00, 6'd0, 1'b0);         // unknown status code
      queue_item(OP_STATUS, ST_START, 8'h00, 6'd0, 1'b0);
      queue_item(OP_STATUS, ST_SLA_W_ACK, 8'h00, 6'd0, 1'b0);
      queue_item(OP_STATUS, ST_DATA_TX_ACK, 8'h00, 6'd0, 1'b0);
      queue_item(OP_STATUS, ST_DATA_TX_ACK, 8'h00, 6'd0, 1'b0); // clean end, no stop
      wait_quiet();

      // Directed: read transfer without ack checking
      set_config(0, 1, 2, 1, 0, 0, 15);
      queue_item(OP_START, 8'h00, 8'h00, 6'd0, 1'b0);
      queue_item(OP_STATUS, ST_START, 8'h00, 6'd0, 1'b0);
      queue_item(OP_STATUS, ST_SLA_R_NACK, 8'h00, 6'd0, 1'b0);
      queue_item(OP_STATUS, ST_DATA_RX_ACK, 8'hFF, 6'd0, 1'b0);
      queue_item(OP_STATUS, ST_DATA_RX_NACK, 8'h00, 6'd0, 1'b0);
      wait_quiet();

      // Random phases, extremes first
      for (int p = 0; p < 7; p++) begin
         case (p)
            0: set_config(127, 0, 64, 1, 1, 15, 15);
            1: set_config(0, 1, 0, 0, 0, 0, 0);
            default: set_config($urandom_range(127), $urandom_range(1), $urandom_range(1, 6),
                                $urandom_range(1), $urandom_range(1), $urandom_range(3),
                                $urandom_range(3));
         endcase
         phase_start = queued_total;
         while (queued_total - phase_start < 20) queue_transfer();
         wait_quiet();
      end

      // Receive overflow: read far past the buffer so the count saturates
      set_config($urandom_range(127), 1, 64, 1, 1, 2, 10);
      queue_item(OP_START, 8'h00, 8'h00, 6'd0, 1'b0);
      queue_item(OP_STATUS, ST_START, 8'h00, 6'd0, 1'b0);
      queue_item(OP_STATUS, ST_SLA_R_ACK, 8'h00, 6'd0, 1'b0);
      for (int k = 0; k < 130; k++)
         queue_item(OP_STATUS, ST_DATA_RX_ACK, 8'($urandom_range(255)),
                    6'($urandom_range(63)), 1'b0);
      queue_item(OP_STATUS, ST_DATA_RX_NACK, 8'($urandom_range(255)), 6'd0, 1'b0);
      wait_quiet();

      if (failures == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
